// ----- rtl/lbcg_pkg.sv -----
package lbcg_pkg;

	localparam int unsigned NUM_CORES = 4;
	localparam int unsigned MIN_CORES = 1;
	localparam int unsigned LOAD_W = 10;
	localparam int unsigned CNT_W = 3;
	localparam int unsigned LOCK_W = 16;
	localparam int unsigned NUM_BANDS = 4;

	// 4 bits so that a count of eight still compares correctly
	localparam logic [3:0] CORES_CMP = 4'(NUM_CORES);
	localparam logic [CNT_W-1:0] CORES_TGT = CNT_W'(NUM_CORES);
	localparam logic [CNT_W-1:0] MIN_TGT = CNT_W'(MIN_CORES);

	localparam logic [CNT_W-1:0] RST_MIN_ONLINE = 3'd2;
	localparam logic [CNT_W-1:0] RST_MAX_ONLINE = 3'd4;
	localparam logic [CNT_W-1:0] RST_BOOST_CORES = 3'd2;
	localparam logic [LOCK_W-1:0] RST_LOCK_TICKS = 16'd2000;

	// band i gives target i+1: down < avg <= up
	localparam logic [LOAD_W-1:0] BAND_UP [NUM_BANDS] = '{10'd50, 10'd100, 10'd150, 10'd410};
	localparam logic [LOAD_W-1:0] BAND_DOWN [NUM_BANDS] = '{10'd0, 10'd40, 10'd80, 10'd140};

	typedef enum logic [1:0] {
		KIND_EVAL    = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_SUSPEND = 2'd2,
		KIND_RESUME  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_UP   = 2'd1,
		ACT_DOWN = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_MIN_ONLINE  = 2'd0,
		REG_MAX_ONLINE  = 2'd1,
		REG_BOOST_CORES = 2'd2,
		REG_LOCK_TICKS  = 2'd3
	} reg_idx_t;

	// first matching band wins, no match gives zero
	function automatic logic [CNT_W-1:0] band_target(input logic [LOAD_W-1:0] avg);
		logic [CNT_W-1:0] t;
		t = '0;
		for (int i = NUM_BANDS - 1; i >= 0; i--) begin
			if (avg <= BAND_UP[i] && avg > BAND_DOWN[i])
				t = CNT_W'(i + 1);
		end
		return t;
	endfunction

endpackage

// ----- rtl/lbcg_in_if.sv -----
interface lbcg_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [9:0] load_sample;
	logic [2:0] online_count;
	logic       boost_request;

	modport source (
		output valid, kind, load_sample, online_count, boost_request,
		input  ready
	);
	modport sink (
		input  valid, kind, load_sample, online_count, boost_request,
		output ready
	);
endinterface

// ----- rtl/lbcg_out_if.sv -----
interface lbcg_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [2:0] target_cores;
	logic [9:0] average_load;
	logic       lock_active;

	modport source (
		output valid, action, target_cores, average_load, lock_active,
		input  ready
	);
	modport sink (
		input  valid, action, target_cores, average_load, lock_active,
		output ready
	);
endinterface

// ----- rtl/lbcg_cfg_if.sv -----
interface lbcg_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ----- rtl/load_based_core_count_governor_unit.sv -----
// channel | dir | word                                          | accepted when
// req     | in  | kind, load_sample, online_count, boost_request | req.valid && req.ready
// rsp     | out | action, target_cores, average_load, lock_active | rsp.valid && rsp.ready
// cfg     | in  | index, data                                   | cfg.valid && cfg.ready
//
// one word per cycle sustained while rsp is not stalled; each word is held in the input
// register and is then loaded into the result register, from which its result is offered.
// the path from input register to result register (history sum update, reciprocal multiply
// for the average, band lookup and clamp) sets the cycle time.
// reset clears the history ring, the lock counter and the suspend flag and loads the
// register defaults; a stalled rsp holds the result and the input register, and req.ready
// drops only while both are full. cfg is always ready.
module load_based_core_count_governor_unit #(
	parameter int unsigned HIST_LEN = 10
) (
	input logic        clk,
	input logic        arst_n,
	lbcg_in_if.sink    req,
	lbcg_out_if.source rsp,
	lbcg_cfg_if.sink   cfg
);
	import lbcg_pkg::*;

	logic              vld_s1;
	kind_t             kind_s1;
	logic [LOAD_W-1:0] sample_s1;
	logic [CNT_W-1:0]  online_s1;
	logic              boost_s1;

	logic [CNT_W-1:0]  min_q;
	logic [CNT_W-1:0]  max_q;
	logic [CNT_W-1:0]  boost_q;
	logic [LOCK_W-1:0] lock_ticks_q;

	logic [LOCK_W-1:0] lock_q;
	logic              susp_q;
	logic              out_vld_q;

	logic              out_free;
	logic              fire_s1;
	logic              eval_en;
	logic [LOAD_W-1:0] avg;
	logic [CNT_W-1:0]  band;
	logic [CNT_W-1:0]  clamped;
	action_t           act;
	logic [CNT_W-1:0]  tgt;
	logic [LOCK_W-1:0] lock_d;
	logic              susp_d;

	assign out_free = !out_vld_q || rsp.ready;
	assign fire_s1 = vld_s1 && out_free;
	assign req.ready = !vld_s1 || out_free;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_vld_q;
	assign eval_en = fire_s1 && kind_s1 == KIND_EVAL && !susp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (req.ready)
			vld_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1 <= kind_t'(req.kind);
			sample_s1 <= req.load_sample;
			online_s1 <= req.online_count;
			boost_s1 <= req.boost_request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= RST_MIN_ONLINE;
			max_q <= RST_MAX_ONLINE;
			boost_q <= RST_BOOST_CORES;
			lock_ticks_q <= RST_LOCK_TICKS;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_MIN_ONLINE:  min_q <= cfg.data[CNT_W-1:0];
				REG_MAX_ONLINE:  max_q <= cfg.data[CNT_W-1:0];
				REG_BOOST_CORES: boost_q <= cfg.data[CNT_W-1:0];
				REG_LOCK_TICKS:  lock_ticks_q <= cfg.data[LOCK_W-1:0];
				default: ;
			endcase
		end
	end

	lbcg_history #(
		.HIST_LEN(HIST_LEN)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (eval_en),
		.sample (sample_s1),
		.avg    (avg)
	);

	assign band = band_target(avg);
	assign clamped = (band > max_q) ? max_q : ((band < min_q) ? min_q : band);

	always_comb begin
		act = ACT_NONE;
		tgt = '0;
		lock_d = lock_q;
		susp_d = susp_q;
		case (kind_s1)
			KIND_TICK: begin
				if (lock_q != '0)
					lock_d = lock_q - 1'b1;
			end
			KIND_SUSPEND: begin
				lock_d = '0;
				susp_d = 1'b1;
				act = ACT_DOWN;
				tgt = MIN_TGT;
			end
			KIND_RESUME: begin
				susp_d = 1'b0;
				act = ACT_UP;
				tgt = CORES_TGT;
				lock_d = lock_ticks_q;
			end
			KIND_EVAL: begin
				if (!susp_q) begin
					// all-cores and single-core locks come before boost and bands
					if ({1'b0, min_q} == CORES_CMP) begin
						if (online_s1 != min_q) begin
							act = ACT_UP;
							tgt = min_q;
						end
					end else if (max_q == MIN_TGT) begin
						if (online_s1 != max_q) begin
							act = ACT_DOWN;
							tgt = max_q;
						end
					end else if (boost_s1 && online_s1 < boost_q) begin
						act = ACT_UP;
						tgt = boost_q;
					end else if (clamped > online_s1) begin
						act = ACT_UP;
						tgt = clamped;
					end else if (clamped < online_s1) begin
						act = ACT_DOWN;
						tgt = clamped;
					end
					if (act == ACT_UP)
						lock_d = lock_ticks_q;
					// lowering is held off while the down-lock runs
					if (act == ACT_DOWN && lock_q != '0) begin
						act = ACT_NONE;
						tgt = '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= '0;
			susp_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				lock_q <= lock_d;
				susp_q <= susp_d;
			end
			if (fire_s1)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp.action <= act;
			rsp.target_cores <= tgt;
			rsp.average_load <= avg;
			rsp.lock_active <= (lock_d != '0);
		end
	end

`ifndef ASSERT_OFF
	a_none_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.action == ACT_NONE |-> rsp.target_cores == '0)
		else $error("no-change result carries a target");

	a_down_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.action == ACT_DOWN |-> !rsp.lock_active)
		else $error("take-down result issued while lock active");

	a_suspend_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && kind_s1 == KIND_SUSPEND |=> lock_q == '0 && susp_q)
		else $error("suspend left lock or flag wrong");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !out_free |-> !req.ready)
		else $error("input taken while both stages full");
`endif

endmodule

// ----- rtl/lbcg_history.sv -----
module lbcg_history #(
	parameter int unsigned HIST_LEN = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [lbcg_pkg::LOAD_W-1:0]  sample,
	output logic [lbcg_pkg::LOAD_W-1:0]  avg
);
	import lbcg_pkg::*;

	localparam int unsigned SUM_W = $clog2(HIST_LEN * ((1 << LOAD_W) - 1) + 1);
	localparam int unsigned SLOT_W = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
	// exact reciprocal for every sum below 2**SUM_W
	localparam int unsigned SHIFT = SUM_W + $clog2(HIST_LEN);
	localparam int unsigned RECIP_W = SHIFT + 1;
	localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(HIST_LEN) - 64'd1)
		/ 64'(HIST_LEN);
	localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HIST_LEN - 1);

	logic [LOAD_W-1:0]        ring_q [HIST_LEN];
	logic [SLOT_W-1:0]        slot_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         sum_new;
	logic [SUM_W+RECIP_W-1:0] prod;

	// wraps mod 2**SUM_W on the way, the final sum is exact
	assign sum_new = wr_en ? sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(sample) : sum_q;
	assign prod = (SUM_W + RECIP_W)'(sum_new) * (SUM_W + RECIP_W)'(RECIP);
	assign avg = prod[SHIFT +: LOAD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++)
				ring_q[i] <= '0;
			slot_q <= '0;
			sum_q <= '0;
		end else if (wr_en) begin
			ring_q[slot_q] <= sample;
			slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			sum_q <= sum_new;
		end
	end

endmodule
